/* sv/crll_pkg.sv */
package crll_pkg;

   // Row geometry
   localparam int ROW_WIDTH = 320;
   localparam int COL_W = 9;
   localparam logic [COL_W-1:0] ROW_WIDTH_C = COL_W'(ROW_WIDTH);
   localparam logic [COL_W-1:0] LAST_COL_C = COL_W'(ROW_WIDTH - 1);
   localparam logic [COL_W:0] HALF_ROW_C = (COL_W + 1)'(ROW_WIDTH / 2);
   localparam logic [COL_W-1:0] COUNT_MAX_C = {COL_W{1'b1}};

   // Field widths
   localparam int PIX_W = 8;
   localparam int THR_W = 8;
   localparam int MINW_W = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 9;
   localparam int RSP_DATA_W = 48;

   // Register reset values
   localparam logic [THR_W-1:0] THR_RESET_C = 8'd80;
   localparam logic [MINW_W-1:0] MINW_RESET_C = 9'd20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BW_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN_WIDTH = 1'b1;

   // Pixel held in the input register
   typedef struct packed {
      logic valid;
      logic [PIX_W-1:0] pixel;
      logic row_end;
   } pix_type;

   // One row result
   typedef struct packed {
      logic [COL_W-1:0] run_start;
      logic [COL_W-1:0] run_end;
      logic [COL_W-1:0] run_width;
      logic [COL_W-1:0] white_count;
      logic signed [COL_W-1:0] line_error;
   } result_type;

endpackage

/* sv/camera_row_line_locator_top.sv */
// A row's last pixel leaves the input register and its row result is registered onto rsp.
// Throughput: one pixel per cycle unless the output stalls; the run tracker updates
// its state from the input register, so pixels stream back to back.
// A pixel stalls only while a row result waits and the held pixel ends a row.
// Reset (synchronous, active high) clears the row state and loads the
// threshold 80 and minimum run width 20.
module camera_row_line_locator_top
   import crll_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [PIX_W-1:0] req_tdata,   // pixel[7:0]
   input  logic req_tlast,               // row_end
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // run_start[8:0], run_end[17:9], run_width[26:18], white_count[35:27],
   // line_error[44:36], zero[47:45]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [MINW_W-1:0] minw_ff, minw_in;
   pix_type pix;
   result_type result;
   logic row_last, advance, out_free;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // Configuration registers
   always_comb begin
      thr_in = thr_ff;
      minw_in = minw_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BW_THRESHOLD: thr_in = csr_wdata[THR_W-1:0];
            CSR_MIN_RUN_WIDTH: minw_in = csr_wdata[MINW_W-1:0];
            default: ;
         endcase
      end
   end

   crll_in_reg u_in_reg (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .pixel(req_tdata),
      .row_end(req_tlast),
      .advance(advance),
      .pix(pix)
   );

   crll_tracker u_tracker (
      .clock(clock),
      .reset(reset),
      .pix(pix),
      .advance(advance),
      .bw_threshold(thr_ff),
      .min_run_width(minw_ff),
      .row_last(row_last),
      .result(result)
   );

   // Move the held pixel on unless its result has nowhere to go
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance = pix.valid && (out_free || !row_last);

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in = rsp_ff;
      if (advance && row_last) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET_C;
         minw_ff <= MINW_RESET_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         minw_ff <= minw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_ff.line_error, rsp_ff.white_count, rsp_ff.run_width,
                       rsp_ff.run_end, rsp_ff.run_start};

endmodule

/* sv/crll_in_reg.sv */
module crll_in_reg
   import crll_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [PIX_W-1:0] pixel,
   input  logic row_end,
   input  logic advance,
   output pix_type pix
);

   logic valid_ff, valid_in;
   logic [PIX_W-1:0] pixel_ff, pixel_in;
   logic row_end_ff, row_end_in;
   logic take;

   // Take a new transfer when the register is empty or draining this cycle
   assign req_tready = !valid_ff || advance;
   assign take = req_tvalid && req_tready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      pixel_in = take ? pixel : pixel_ff;
      row_end_in = take ? row_end : row_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pixel_ff <= pixel_in;
      row_end_ff <= row_end_in;
   end

   assign pix = '{valid: valid_ff, pixel: pixel_ff, row_end: row_end_ff};

endmodule

/* sv/crll_tracker.sv */
module crll_tracker
   import crll_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  pix_type pix,
   input  logic advance,
   input  logic [THR_W-1:0] bw_threshold,
   input  logic [MINW_W-1:0] min_run_width,
   output logic row_last,
   output result_type result
);

   logic [COL_W-1:0] col_ff, col_in;
   logic in_run_ff, in_run_in;
   logic locked_ff, locked_in;
   logic [COL_W-1:0] start_ff, start_in;
   logic [COL_W-1:0] end_ff, end_in;
   logic [COL_W-1:0] total_ff, total_in;

   logic white;
   logic [COL_W:0] span;
   logic [COL_W:0] pos_sum;
   logic [COL_W:0] err_wide;
   logic [COL_W-1:0] n_start, n_end, n_total;
   logic n_run, n_locked;

   assign white = pix.pixel >= bw_threshold;
   assign span = {1'b0, col_ff} - {1'b0, start_ff};

   // Update run state for the current pixel
   always_comb begin
      n_total = (white && total_ff != COUNT_MAX_C) ? total_ff + 1'b1 : total_ff;
      n_run = in_run_ff;
      n_locked = locked_ff;
      n_start = start_ff;
      n_end = end_ff;
      if (!locked_ff) begin
         if (white && !in_run_ff) begin
            n_run = 1'b1;
            n_start = col_ff;
         end else if (!white && in_run_ff) begin
            n_end = col_ff;
            if (!span[COL_W] && span[COL_W-1:0] > min_run_width) begin
               n_locked = 1'b1;
            end else begin
               n_run = 1'b0;
            end
         end
      end
   end

   assign row_last = pix.row_end || (col_ff >= LAST_COL_C);

   // Build the row result from the updated state
   always_comb begin
      pos_sum = {1'b0, n_start} + {1'b0, n_end};
      err_wide = {1'b0, pos_sum[COL_W:1]} - HALF_ROW_C;
      result.run_start = n_start;
      result.run_end = n_end;
      result.run_width = n_locked ? n_end - n_start : '0;
      result.white_count = n_total;
      result.line_error = err_wide[COL_W-1:0];
   end

   // Advance the row or clear it after its last pixel
   always_comb begin
      col_in = col_ff;
      in_run_in = in_run_ff;
      locked_in = locked_ff;
      start_in = start_ff;
      end_in = end_ff;
      total_in = total_ff;
      if (advance) begin
         if (row_last) begin
            col_in = '0;
            in_run_in = 1'b0;
            locked_in = 1'b0;
            start_in = '0;
            end_in = ROW_WIDTH_C;
            total_in = '0;
         end else begin
            col_in = col_ff + 1'b1;
            in_run_in = n_run;
            locked_in = n_locked;
            start_in = n_start;
            end_in = n_end;
            total_in = n_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         in_run_ff <= 1'b0;
         locked_ff <= 1'b0;
         start_ff <= '0;
         end_ff <= ROW_WIDTH_C;
         total_ff <= '0;
      end else begin
         col_ff <= col_in;
         in_run_ff <= in_run_in;
         locked_ff <= locked_in;
         start_ff <= start_in;
         end_ff <= end_in;
         total_ff <= total_in;
      end
   end

endmodule
